// ===== hdl/brc_pkg.sv =====
// Shared constants, command/status types and helpers for the bitmap collision block.
package brc_pkg;

    // Storage size
    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 256;

    // Derived widths
    localparam int ROW_AW = $clog2(MAX_ROWS);
    localparam int CNT_W  = $clog2(MAX_ROWS + 1);
    localparam int COLI_W = $clog2(MAX_COLUMNS);
    localparam int CMP_W  = 13;
    localparam int DEPTH_W = 11;

    // Input command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic CFG_MAP_WIDTH  = 1'b0;
    localparam logic CFG_MAP_HEIGHT = 1'b1;

    // Depth limits
    localparam int DEPTH_MAX = 1023;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture an accepted item
        logic wr_read;   // read the row to be modified
        logic wr_write;  // write back the merged row
        logic issue;     // read the next scan row
        logic load_out;  // capture the result item
    } brc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_end;  // no scan rows left to issue
    } brc_status_t;

    // Clamp a wide signed depth to the 11-bit result range
    function automatic logic signed [DEPTH_W-1:0] sat_depth(input logic signed [CMP_W-1:0] d);
        logic signed [CMP_W-1:0] lim;
        lim = CMP_W'(DEPTH_MAX);
        if (d > lim)
            return DEPTH_W'(DEPTH_MAX);
        else if (d < -lim)
            return DEPTH_W'(-DEPTH_MAX);
        else
            return d[DEPTH_W-1:0];
    endfunction

endpackage

// ===== hdl/brc_ctrl.sv =====
// Controller state machine: sequences cell writes, row scans and result hand-off.
module brc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                command,
    output logic                out_valid,
    input  logic                out_ready,
    input  brc_pkg::brc_status_t status,
    output brc_pkg::brc_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WR_RD = 3'd1;
    localparam logic [2:0] S_WR_WR = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (command == brc_pkg::CMD_QUERY) ? S_SCAN : S_WR_RD;
                end
            end
            S_WR_RD:
            begin
                cmd.wr_read = 1'b1;
                state_next  = S_WR_WR;
            end
            S_WR_WR:
            begin
                cmd.wr_write = 1'b1;
                state_next   = S_DONE;
            end
            S_SCAN:
            begin
                // last row result is folded in on the edge that leaves this state
                if (status.scan_end)
                    state_next = S_DONE;
                else
                    cmd.issue = 1'b1;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (cmd.load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/brc_datapath.sv =====
// Datapath: row bitmap memory, rectangle setup, scan accumulator and result register.
module brc_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  brc_pkg::brc_cmd_t           cmd,
    output brc_pkg::brc_status_t        status,
    input  logic [6:0]                  map_width,
    input  logic [8:0]                  map_height,
    input  logic                        command,
    input  logic [5:0]                  cell_x,
    input  logic [7:0]                  cell_y,
    input  logic [7:0]                  cell_byte,
    input  logic signed [9:0]           rect_left,
    input  logic signed [9:0]           rect_top,
    input  logic signed [9:0]           rect_right,
    input  logic signed [9:0]           rect_bottom,
    output logic                        is_query,
    output logic                        any_hit,
    output logic signed [10:0]          depth_from_top,
    output logic signed [10:0]          depth_from_bottom
);

    localparam int NC  = brc_pkg::MAX_COLUMNS;
    localparam int NR  = brc_pkg::MAX_ROWS;
    localparam int AW  = brc_pkg::ROW_AW;
    localparam int CW  = brc_pkg::CMP_W;
    localparam int NW  = brc_pkg::CNT_W;
    localparam int XW  = brc_pkg::COLI_W;
    localparam int DW  = brc_pkg::DEPTH_W;

    // Row storage and per-row valid bits (invalid rows read as clear)
    logic [NC-1:0] mem [NR];
    logic          row_valid_reg [NR];
    logic [NC-1:0] rd_data_reg;
    logic          rd_valid_reg;

    // Captured item
    logic                  is_query_reg;
    logic                  col_out_reg;
    logic signed [9:0]     y0_reg, y1_reg;
    logic [NC-1:0]         mask_reg;
    logic [NW-1:0]         cur_reg, end_reg;
    logic [XW-1:0]         wx_reg;
    logic [AW-1:0]         wy_reg;
    logic                  wsolid_reg;
    logic                  wok_reg;

    // Scan pipeline and accumulator
    logic                  live_reg;
    logic [AW-1:0]         row_idx_reg;
    logic                  found_reg, found_next;
    logic [AW-1:0]         first_reg, first_next;
    logic [AW-1:0]         last_reg, last_next;

    // Result register
    logic                  is_query_out_reg;
    logic                  any_hit_reg;
    logic signed [DW-1:0]  dft_reg, dfb_reg;

    // Setup signals
    logic signed [CW-1:0]  x0_s, x1_s, y0_s, y1_s, w_s, h_s, ys_s, ye_s;
    logic                  col_out, empty;
    logic [NC-1:0]         mask;
    logic [NW-1:0]         cur_init, end_init;

    logic [AW-1:0]         rd_addr;
    logic                  rd_en;
    logic [NC-1:0]         row_rd;
    logic [NC-1:0]         merged;
    logic                  row_hit;

    logic signed [CW-1:0]  d_span, d_top, d_bot;
    logic signed [DW-1:0]  dft_next, dfb_next;

    // Rectangle setup against the map size in use
    always_comb
    begin
        x0_s = CW'(rect_left);
        x1_s = CW'(rect_right);
        y0_s = CW'(rect_top);
        y1_s = CW'(rect_bottom);
        w_s  = (map_width > 7'(NC)) ? CW'(NC) : CW'(map_width);
        h_s  = (CW'(map_height) > CW'(NR)) ? CW'(NR) : CW'(map_height);
        col_out = (x0_s < 0) || (x1_s >= w_s);
        ys_s = (y0_s < 0) ? '0 : y0_s;
        ye_s = (y1_s < h_s) ? y1_s : h_s;
        empty = col_out || (ys_s >= ye_s);
        cur_init = empty ? '0 : ys_s[NW-1:0];
        end_init = empty ? '0 : ye_s[NW-1:0];
        for (int i = 0; i < NC; i++)
            mask[i] = (CW'(i) >= x0_s) && (CW'(i) <= x1_s);
    end

    assign status.scan_end = (cur_reg >= end_reg);

    // Memory read address: write row or next scan row
    assign rd_en   = cmd.wr_read || cmd.issue;
    assign rd_addr = cmd.wr_read ? wy_reg : cur_reg[AW-1:0];
    assign row_rd  = rd_valid_reg ? rd_data_reg : '0;

    // Read-modify-write merge for one cell
    always_comb
    begin
        merged = row_rd;
        merged[wx_reg] = wsolid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
        if (cmd.wr_write && wok_reg)
            mem[wy_reg] <= merged;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NR; i++)
                row_valid_reg[i] <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
                rd_valid_reg <= row_valid_reg[rd_addr];
            if (cmd.wr_write && wok_reg)
                row_valid_reg[wy_reg] <= 1'b1;
        end
    end

    // Item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            is_query_reg <= (command == brc_pkg::CMD_QUERY);
            col_out_reg  <= col_out;
            y0_reg       <= rect_top;
            y1_reg       <= rect_bottom;
            mask_reg     <= mask;
            end_reg      <= (command == brc_pkg::CMD_QUERY) ? end_init : '0;
            wx_reg       <= XW'(cell_x);
            wy_reg       <= AW'(cell_y);
            wsolid_reg   <= (cell_byte != 8'd0);
            wok_reg      <= (32'(cell_x) < NC) && (32'(cell_y) < NR);
        end
    end

    // Scan row counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cur_reg <= '0;
        else if (cmd.load)
            cur_reg <= (command == brc_pkg::CMD_QUERY) ? cur_init : '0;
        else if (cmd.issue)
            cur_reg <= cur_reg + NW'(1);
    end

    // Hit accumulation on the registered row, in the cycle after its read
    assign row_hit = live_reg && ((row_rd & mask_reg) != '0);

    always_comb
    begin
        found_next = found_reg;
        first_next = first_reg;
        last_next  = last_reg;
        if (cmd.load)
            found_next = 1'b0;
        else if (row_hit)
        begin
            if (!found_reg)
                first_next = row_idx_reg;
            found_next = 1'b1;
            last_next  = row_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            live_reg  <= cmd.issue;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
            row_idx_reg <= cur_reg[AW-1:0];
        first_reg <= first_next;
        last_reg  <= last_next;
    end

    // Result depths
    always_comb
    begin
        d_span = CW'(y1_reg) - CW'(y0_reg);
        d_top  = CW'(last_reg) + CW'(1) - CW'(y0_reg);
        d_bot  = CW'(y1_reg) - CW'(first_reg);
        if (!is_query_reg)
        begin
            dft_next = '0;
            dfb_next = '0;
        end
        else if (col_out_reg)
        begin
            dft_next = brc_pkg::sat_depth(d_span);
            dfb_next = brc_pkg::sat_depth(d_span);
        end
        else if (found_reg)
        begin
            dft_next = brc_pkg::sat_depth(d_top);
            dfb_next = brc_pkg::sat_depth(d_bot);
        end
        else
        begin
            dft_next = '0;
            dfb_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            is_query_out_reg <= is_query_reg;
            any_hit_reg      <= is_query_reg && (col_out_reg || found_reg);
            dft_reg          <= dft_next;
            dfb_reg          <= dfb_next;
        end
    end

    assign is_query          = is_query_out_reg;
    assign any_hit           = any_hit_reg;
    assign depth_from_top    = dft_reg;
    assign depth_from_bottom = dfb_reg;

endmodule

// ===== hdl/bitmap_rect_collision_top.sv =====
// Top level of the bitmap rectangle collision block: config registers, controller, datapath.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  in      | input     | in_valid / in_ready    | command, cell_x, cell_y, cell_byte, rect_*
//  out     | output    | out_valid / out_ready  | is_query, any_hit, depth_from_top/bottom
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A cell write runs through row read, merge and write, and result. A query scans the rows
// left after clipping (at most MAX_ROWS), then hands off its result; the single memory read
// port fetches one row per cycle. One item is in work at a time.
// Reset clears the map at once through per-row valid bits; no clearing pass is needed.
// A stalled result holds in the output register; the next item is accepted meanwhile.
module bitmap_rect_collision_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  logic [5:0]         cell_x,
    input  logic [7:0]         cell_y,
    input  logic [7:0]         cell_byte,
    input  logic signed [9:0]  rect_left,
    input  logic signed [9:0]  rect_top,
    input  logic signed [9:0]  rect_right,
    input  logic signed [9:0]  rect_bottom,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               is_query,
    output logic               any_hit,
    output logic signed [10:0] depth_from_top,
    output logic signed [10:0] depth_from_bottom,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [8:0]         cfg_data
);

    logic [6:0] map_width_reg;
    logic [8:0] map_height_reg;

    brc_pkg::brc_cmd_t    cmd;
    brc_pkg::brc_status_t status;

    // Configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= 7'd64;
            map_height_reg <= 9'd256;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                brc_pkg::CFG_MAP_WIDTH:  map_width_reg  <= cfg_data[6:0];
                brc_pkg::CFG_MAP_HEIGHT: map_height_reg <= cfg_data;
                default:                 map_width_reg  <= map_width_reg;
            endcase
        end
    end

    brc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    brc_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .map_width         (map_width_reg),
        .map_height        (map_height_reg),
        .command           (command),
        .cell_x            (cell_x),
        .cell_y            (cell_y),
        .cell_byte         (cell_byte),
        .rect_left         (rect_left),
        .rect_top          (rect_top),
        .rect_right        (rect_right),
        .rect_bottom       (rect_bottom),
        .is_query          (is_query),
        .any_hit           (any_hit),
        .depth_from_top    (depth_from_top),
        .depth_from_bottom (depth_from_bottom)
    );

endmodule

// ===== hdl/brc_checker.sv =====
// Port-level checker for the bitmap collision block, bound to the top level.
module brc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               is_query,
    input logic               any_hit,
    input logic signed [10:0] depth_from_top,
    input logic signed [10:0] depth_from_bottom,
    input logic               cfg_ready
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(is_query) && $stable(any_hit)
            && $stable(depth_from_top) && $stable(depth_from_bottom)))
        else $error("result changed while stalled");

    // Write acknowledge carries no hit and zero depths
    a_write_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_query) |-> (!any_hit && depth_from_top == 11'sd0
            && depth_from_bottom == 11'sd0))
        else $error("write acknowledge with nonzero fields");

    // A query without a hit has zero depths
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_query && !any_hit) |-> (depth_from_top == 11'sd0
            && depth_from_bottom == 11'sd0))
        else $error("miss with nonzero depth");

    // One item in work: input closes after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item accepted while busy");

    // Configuration port never stalls
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind bitmap_rect_collision_top brc_checker u_brc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .is_query          (is_query),
    .any_hit           (any_hit),
    .depth_from_top    (depth_from_top),
    .depth_from_bottom (depth_from_bottom),
    .cfg_ready         (cfg_ready)
);
